// ----- design/bchm_pkg.sv -----
// Shared types and constants for the border color histogram mode block.
// Holds the controller state type, the register indexes and default sizes.
// No dependencies.
package bchm_pkg;

    localparam int unsigned LEVEL_BITS   = 8;
    localparam int unsigned CHANNELS_RGB = 3;

    localparam int unsigned BIN_BITS_DEF   = 4;
    localparam int unsigned COORD_BITS_DEF = 16;
    localparam int unsigned COUNT_BITS_DEF = 24;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [8:0] THICKNESS_RST = 9'd3;
    localparam logic [3:0] EXPONENT_RST  = 4'd4;
    localparam logic [2:0] CHANNELS_RST  = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_LEFT    = 3'd0,
        CFG_REGION_TOP     = 3'd1,
        CFG_REGION_RIGHT   = 3'd2,
        CFG_REGION_BOTTOM  = 3'd3,
        CFG_THICKNESS      = 3'd4,
        CFG_EXPONENT       = 3'd5,
        CFG_CHANNELS       = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_ACCUM,
        ST_DRAIN,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

// ----- design/border_color_histogram_mode.sv -----
// Border color histogram mode: top level with histogram memory and scan controller.
// Depends on bchm_pkg.
//
// Usage: pixels enter on the s_axis channel, one word per pixel, with tlast on the
// last pixel of a region. Border pixels are quantized and counted in a histogram of
// 2^(3*BIN_BITS) bins held in one synchronous memory (read, increment, write back,
// with forwarding of the last write). A pixel is taken every cycle while counting.
// After the tlast word the block stops taking pixels, drains its two-stage update
// pipe, then sweeps the memory one bin per cycle, finding the first largest bin and
// zeroing each bin as it is read. The result word (bin center color and count)
// appears on m_axis once the sweep is over; the sweep length is set by the single
// memory read port. The result sits in an output register until taken; pixel input
// resumes while it waits, but the next sweep starts only once the earlier result
// has been taken. Reset: configuration returns to its defaults and a clearing pass
// writes zero to all 2^(3*BIN_BITS) bins, one per cycle, with s_axis_tready low
// throughout. Configuration is written through cfg_we/cfg_index/cfg_data, by the
// user only while the block is idle; the block itself does not enforce this.
module border_color_histogram_mode #(
    parameter int unsigned BIN_BITS   = bchm_pkg::BIN_BITS_DEF,
    parameter int unsigned COORD_BITS = bchm_pkg::COORD_BITS_DEF,
    parameter int unsigned COUNT_BITS = bchm_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bchm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bchm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pixel_x[15:0], pixel_y[31:16], red_level[39:32], green_level[47:40],
    // blue_level[55:48]
    input  logic [55:0]                         s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mode_red[7:0], mode_green[15:8], mode_blue[23:16], mode_count[47:24]
    output logic [47:0]                         m_axis_tdata
);
    import bchm_pkg::*;

    localparam int unsigned IDX_W   = CHANNELS_RGB * BIN_BITS;
    localparam int unsigned BINS    = 1 << IDX_W;
    localparam int unsigned SUM_W   = COORD_BITS + 2;
    localparam int unsigned MIN_EXP = LEVEL_BITS - BIN_BITS;

    // Configuration registers
    logic [15:0] region_left_reg, region_top_reg, region_right_reg, region_bottom_reg;
    logic [8:0]  thickness_reg;
    logic [3:0]  exponent_reg;
    logic [2:0]  channels_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            region_left_reg   <= '0;
            region_top_reg    <= '0;
            region_right_reg  <= '0;
            region_bottom_reg <= '0;
            thickness_reg     <= THICKNESS_RST;
            exponent_reg      <= EXPONENT_RST;
            channels_reg      <= CHANNELS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REGION_LEFT:   region_left_reg   <= cfg_data;
                CFG_REGION_TOP:    region_top_reg    <= cfg_data;
                CFG_REGION_RIGHT:  region_right_reg  <= cfg_data;
                CFG_REGION_BOTTOM: region_bottom_reg <= cfg_data;
                CFG_THICKNESS:     thickness_reg     <= cfg_data[8:0];
                CFG_EXPONENT:      exponent_reg      <= cfg_data[3:0];
                CFG_CHANNELS:      channels_reg      <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Effective exponent, clamped to [8 - BIN_BITS, 8]
    logic [3:0] eff_exp;
    always_comb begin
        if (exponent_reg < 4'(MIN_EXP))
            eff_exp = 4'(MIN_EXP);
        else if (exponent_reg > 4'(LEVEL_BITS))
            eff_exp = 4'(LEVEL_BITS);
        else
            eff_exp = exponent_reg;
    end

    // Controller
    state_t state_reg, state_next;
    logic [IDX_W-1:0] addr_reg;
    logic in_accept, init_active, scan_active, load_result, addr_last;

    assign addr_last = (addr_reg == '1);

    logic s1_v_reg, s2_v_reg, m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:  if (addr_last) state_next = ST_ACCUM;
            ST_ACCUM: if (in_accept && s_axis_tlast) state_next = ST_DRAIN;
            ST_DRAIN: if (!s1_v_reg && !s2_v_reg && !m_valid_reg) state_next = ST_SCAN;
            ST_SCAN:  if (addr_last) state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_ACCUM;
            default:  state_next = ST_INIT;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        init_active   = 1'b0;
        scan_active   = 1'b0;
        load_result   = 1'b0;
        unique case (state_reg)
            ST_INIT:  init_active   = 1'b1;
            ST_ACCUM: s_axis_tready = 1'b1;
            ST_DRAIN: ;
            ST_SCAN:  scan_active   = 1'b1;
            ST_FLUSH: load_result   = 1'b1;
            default: ;
        endcase
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (init_active || scan_active)
                addr_reg <= addr_reg + 1'b1;
        end
    end

    // Stage 0: border test and bin index from the incoming word
    logic [COORD_BITS-1:0] px, py;
    logic [SUM_W-1:0] x_ext, y_ext, t_ext, l_ext, tp_ext, r_ext, b_ext;
    logic on_border;
    logic [LEVEL_BITS-1:0] red_sh, green_sh, blue_sh;
    logic [BIN_BITS-1:0] rq, gq, bq;
    logic [IDX_W-1:0] in_idx;

    assign px     = s_axis_tdata[COORD_BITS-1:0];
    assign py     = s_axis_tdata[16 +: COORD_BITS];
    assign x_ext  = SUM_W'(px);
    assign y_ext  = SUM_W'(py);
    assign t_ext  = SUM_W'(thickness_reg);
    assign l_ext  = SUM_W'(region_left_reg[COORD_BITS-1:0]);
    assign tp_ext = SUM_W'(region_top_reg[COORD_BITS-1:0]);
    assign r_ext  = SUM_W'(region_right_reg[COORD_BITS-1:0]);
    assign b_ext  = SUM_W'(region_bottom_reg[COORD_BITS-1:0]);

    // x >= r - t is tested as x + t >= r to stay unsigned
    assign on_border = (x_ext < l_ext + t_ext) || (x_ext + t_ext >= r_ext)
                    || (y_ext < tp_ext + t_ext) || (y_ext + t_ext >= b_ext);

    assign red_sh   = s_axis_tdata[39:32] >> eff_exp;
    assign green_sh = s_axis_tdata[47:40] >> eff_exp;
    assign blue_sh  = s_axis_tdata[55:48] >> eff_exp;
    assign rq = red_sh[BIN_BITS-1:0];
    assign gq = (channels_reg > 3'd1) ? green_sh[BIN_BITS-1:0] : '0;
    assign bq = (channels_reg > 3'd2) ? blue_sh[BIN_BITS-1:0] : '0;
    assign in_idx = {rq, gq, bq};

    // Stage 1: index issued to the memory read port
    logic [IDX_W-1:0] s1_idx_reg, s2_idx_reg;
    logic s1_hit_reg, s2_hit_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= in_accept;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk) begin
        s1_idx_reg <= in_idx;
        s1_hit_reg <= on_border;
        s2_idx_reg <= s1_idx_reg;
        s2_hit_reg <= s1_hit_reg;
    end

    // Histogram memory
    logic [COUNT_BITS-1:0] hist_mem [BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0] mem_raddr, mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic mem_we;

    // Stage 2: saturating increment, forwarding the last write on an address match
    logic lw_v_reg;
    logic [IDX_W-1:0] lw_idx_reg;
    logic [COUNT_BITS-1:0] lw_data_reg;
    logic [COUNT_BITS-1:0] count_in, count_inc;
    logic pix_write;

    assign count_in  = (lw_v_reg && lw_idx_reg == s2_idx_reg) ? lw_data_reg : rd_data_reg;
    assign count_inc = (count_in == '1) ? count_in : count_in + 1'b1;
    assign pix_write = s2_v_reg && s2_hit_reg;

    always_comb begin
        mem_raddr = scan_active ? addr_reg : s1_idx_reg;
        if (init_active || scan_active)
        begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = pix_write;
            mem_waddr = s2_idx_reg;
            mem_wdata = count_inc;
        end
    end

    always_ff @(posedge clk) begin
        if (mem_we)
            hist_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk) begin
        rd_data_reg <= hist_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            lw_v_reg <= 1'b0;
        else if (mem_we)
            lw_v_reg <= 1'b1;
    end

    always_ff @(posedge clk) begin
        if (mem_we)
        begin
            lw_idx_reg  <= mem_waddr;
            lw_data_reg <= mem_wdata;
        end
    end

    // Scan: first strictly greatest bin wins
    logic sc_v_reg;
    logic [IDX_W-1:0] sc_idx_reg;
    logic [COUNT_BITS-1:0] best_reg, best_next;
    logic [IDX_W-1:0] bi_reg, bi_next;

    always_comb begin
        best_next = best_reg;
        bi_next   = bi_reg;
        if (sc_v_reg && rd_data_reg > best_reg)
        begin
            best_next = rd_data_reg;
            bi_next   = sc_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            sc_v_reg <= 1'b0;
            best_reg <= '0;
            bi_reg   <= '0;
        end
        else
        begin
            sc_v_reg <= scan_active;
            if (load_result)
            begin
                best_reg <= '0;
                bi_reg   <= '0;
            end
            else
            begin
                best_reg <= best_next;
                bi_reg   <= bi_next;
            end
        end
    end

    always_ff @(posedge clk) begin
        sc_idx_reg <= addr_reg;
    end

    // Bin center: (q << e) + 2^(e-1), low 8 bits
    function automatic logic [LEVEL_BITS-1:0] center_of(input logic [BIN_BITS-1:0] q,
                                                        input logic [3:0] e);
        logic [15:0] v;
        v = 16'(q) << e;
        if (e != 4'd0)
            v = v + (16'd1 << (e - 4'd1));
        return v[LEVEL_BITS-1:0];
    endfunction

    logic [LEVEL_BITS-1:0] c_red, c_green, c_blue;
    logic [31:0] best_ext;
    logic found;

    assign found    = (best_next != '0);
    assign c_red    = found ? center_of(bi_next[2*BIN_BITS +: BIN_BITS], eff_exp) : '0;
    assign c_green  = found ? center_of(bi_next[BIN_BITS +: BIN_BITS], eff_exp) : '0;
    assign c_blue   = found ? center_of(bi_next[BIN_BITS-1:0], eff_exp) : '0;
    assign best_ext = 32'(best_next);

    // Output register
    logic [47:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_result)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (load_result)
            m_data_reg <= {best_ext[23:0], c_blue, c_green, c_red};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks
    a_scan_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (!s1_v_reg && !s2_v_reg))
        else $error("histogram sweep started with pixel updates in flight");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |-> !m_valid_reg)
        else $error("result loaded over a word not yet taken");

    a_pix_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        pix_write |-> (state_reg == ST_ACCUM || state_reg == ST_DRAIN))
        else $error("pixel update collides with clear or sweep");

    a_sweep_ends_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && addr_last) |=> (state_reg == ST_FLUSH && sc_v_reg))
        else $error("last bin of sweep not compared");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench for border_color_histogram_mode: streams region pixels, keeps its own
// border histogram per frame and checks every mode result word against it.
// Depends on bchm_pkg and the border_color_histogram_mode RTL.
module tb;
    import bchm_pkg::*;

    localparam int BINS          = 1 << (CHANNELS_RGB * BIN_BITS_DEF);
    localparam int BIN_MASK      = (1 << BIN_BITS_DEF) - 1;
    localparam int COUNT_MAX     = (1 << COUNT_BITS_DEF) - 1;
    localparam int MIN_SHIFT     = LEVEL_BITS - BIN_BITS_DEF;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PIXELS = 380;
    localparam int RANDOM_FRAMES = 20;

    // first member lands in the top bits, so x sits at bit 0
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] y;
        logic [15:0] x;
    } pixel_t;

    typedef struct packed {
        logic [23:0] count;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // pixel_x[15:0], pixel_y[31:16], red_level[39:32], green_level[47:40],
    // blue_level[55:48]
    logic [55:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // mode_red[7:0], mode_green[15:8], mode_blue[23:16], mode_count[47:24]
    logic [47:0] m_axis_tdata;

    // predictor copy of the registers and the histogram
    logic [15:0] win_left   = '0;
    logic [15:0] win_top    = '0;
    logic [15:0] win_right  = '0;
    logic [15:0] win_bottom = '0;
    logic [8:0]  band_width = THICKNESS_RST;
    logic [3:0]  shift_exp  = EXPONENT_RST;
    logic [2:0]  chan_count = CHANNELS_RST;
    int unsigned bin_tally [BINS];

    mode_t pending_modes [$];

    int          mismatch_count = 0;
    int          pixels_sent    = 0;
    int          frames_sent    = 0;
    int          results_seen   = 0;
    int          cfg_settings   = 0;
    int unsigned cycle_count    = 0;
    bit          no_idle        = 1'b0;

    border_color_histogram_mode dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic int eff_shift();
        int e;
        e = shift_exp;
        if (e < MIN_SHIFT)
            e = MIN_SHIFT;
        if (e > LEVEL_BITS)
            e = LEVEL_BITS;
        return e;
    endfunction

    // outside pixels fail the inner-rectangle test, so they count too
    function automatic bit in_band(input pixel_t p);
        int x, y, t;
        x = p.x;
        y = p.y;
        t = band_width;
        return x < int'(win_left) + t || x >= int'(win_right) - t ||
               y < int'(win_top) + t || y >= int'(win_bottom) - t;
    endfunction

    function automatic void tally_pixel(input pixel_t p);
        int e, rq, gq, bq, idx;
        if (!in_band(p))
            return;
        e  = eff_shift();
        rq = (int'(p.red) >> e) & BIN_MASK;
        gq = (chan_count > 1) ? ((int'(p.green) >> e) & BIN_MASK) : 0;
        bq = (chan_count > 2) ? ((int'(p.blue) >> e) & BIN_MASK) : 0;
        idx = (rq << (2 * BIN_BITS_DEF)) | (gq << BIN_BITS_DEF) | bq;
        if (bin_tally[idx] < COUNT_MAX)
            bin_tally[idx]++;
    endfunction

    function automatic logic [7:0] bin_center(input int q, input int e);
        int half;
        half = (e > 0) ? (1 << (e - 1)) : 0;
        return 8'((q << e) + half);
    endfunction

    // first strictly largest bin in red, green, blue order; clears the histogram
    function automatic mode_t frame_mode();
        int unsigned best;
        int          win, e, i;
        bit          found;
        mode_t       m;
        best  = 0;
        win   = 0;
        found = 1'b0;
        e     = eff_shift();
        for (i = 0; i < BINS; i++)
        begin
            if (bin_tally[i] > best)
            begin
                best  = bin_tally[i];
                win   = i;
                found = 1'b1;
            end
        end
        m = '0;
        if (found)
        begin
            m.red   = bin_center((win >> (2 * BIN_BITS_DEF)) & BIN_MASK, e);
            m.green = bin_center((win >> BIN_BITS_DEF) & BIN_MASK, e);
            m.blue  = bin_center(win & BIN_MASK, e);
        end
        m.count   = best[23:0];
        bin_tally = '{default: 0};
        return m;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic set_reg(input cfg_idx_t idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_REGION_LEFT:   win_left   = val[15:0];
            CFG_REGION_TOP:    win_top    = val[15:0];
            CFG_REGION_RIGHT:  win_right  = val[15:0];
            CFG_REGION_BOTTOM: win_bottom = val[15:0];
            CFG_THICKNESS:     band_width = val[8:0];
            CFG_EXPONENT:      shift_exp  = val[3:0];
            CFG_CHANNELS:      chan_count = val[2:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input int l, input int t, input int r, input int b,
                                input int band, input int shift, input int chans);
        set_reg(CFG_REGION_LEFT, l);
        set_reg(CFG_REGION_TOP, t);
        set_reg(CFG_REGION_RIGHT, r);
        set_reg(CFG_REGION_BOTTOM, b);
        set_reg(CFG_THICKNESS, band);
        set_reg(CFG_EXPONENT, shift);
        set_reg(CFG_CHANNELS, chans);
        cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // tvalid stays high after a word; it drops only in a gap or when idling
    task automatic send_pixel(input pixel_t p, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        tally_pixel(p);
        pixels_sent++;
        if (last)
        begin
            pending_modes.push_back(frame_mode());
            frames_sent++;
        end
    endtask

    // drain every outstanding result, then let the pipe settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (pending_modes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic pixel_t pix(input int x, input int y, input logic [23:0] rgb);
        pixel_t p;
        p.x = x[15:0];
        p.y = y[15:0];
        {p.red, p.green, p.blue} = rgb;
        return p;
    endfunction

    // aim at the band edges, the interior, or anywhere at all
    function automatic logic [15:0] rand_coord(input int lo, input int hi);
        int t, v;
        t = band_width;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 65535);
            1:       v = lo + t - 1;
            2:       v = lo + t;
            3:       v = hi - t - 1;
            4:       v = hi - t;
            5, 6:    v = (lo + t < hi - t) ? $urandom_range(lo + t, hi - t - 1) : lo;
            default: v = (lo < hi) ? $urandom_range(lo, hi - 1) : hi;
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // ---------------------------------------------------------------- result sink

    initial
    begin : sink_pace
        int r, span;
        m_axis_tready = 1'b0;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (span > 0)
                span--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    m_axis_tready <= 1'b1;
                    span = $urandom_range(1, 40);
                end
                else if (r < 90)
                begin
                    m_axis_tready <= 1'b0;
                    span = $urandom_range(1, 3);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    span = $urandom_range(10, 60);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_modes
        mode_t got, want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_modes.size() == 0)
                report_mismatch($sformatf("result word %h with none pending", m_axis_tdata));
            else
            begin
                want = pending_modes.pop_front();
                if (got.red !== want.red)
                    report_mismatch($sformatf("mode_red %0d, want %0d", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("mode_green %0d, want %0d",
                                              got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("mode_blue %0d, want %0d", got.blue, want.blue));
                if (got.count !== want.count)
                    report_mismatch($sformatf("mode_count %0d, want %0d",
                                              got.count, want.count));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_modes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // reset registers put every pixel in the band
    task automatic test_default_registers();
        send_pixel(pix(0, 0, 24'h000000), 1'b0);
        send_pixel(pix(16'hFFFF, 16'hFFFF, 24'hFFFFFF), 1'b0);
        send_pixel(pix(16'h8000, 16'h7FFF, 24'hFFFFFF), 1'b1);
    endtask

    task automatic test_border_band();
        logic [23:0] rim, core;
        rim  = 24'h123456;
        core = 24'hC0C0C0;
        wait_idle();
        apply_config(100, 200, 140, 260, 1, 4, 3);
        send_pixel(pix(100, 230, rim), 1'b0);
        send_pixel(pix(101, 230, core), 1'b0);
        send_pixel(pix(139, 230, rim), 1'b0);
        send_pixel(pix(138, 230, core), 1'b0);
        send_pixel(pix(120, 200, rim), 1'b0);
        send_pixel(pix(120, 259, rim), 1'b0);
        send_pixel(pix(120, 201, core), 1'b0);
        send_pixel(pix(5, 9000, rim), 1'b1);
        // empty frame: only an interior pixel
        wait_idle();
        send_pixel(pix(120, 230, core), 1'b1);
        // a 256-wide band over the full coordinate range
        wait_idle();
        apply_config(0, 0, 65535, 65535, 256, 4, 3);
        send_pixel(pix(255, 1000, rim), 1'b0);
        send_pixel(pix(256, 1000, core), 1'b0);
        send_pixel(pix(65278, 1000, core), 1'b0);
        send_pixel(pix(65279, 1000, rim), 1'b1);
        // zero thickness: only the far edges count
        wait_idle();
        apply_config(10, 10, 20, 20, 0, 4, 3);
        send_pixel(pix(15, 15, core), 1'b0);
        send_pixel(pix(20, 15, rim), 1'b1);
    endtask

    // exponent clamped up and down, channel counts zero to four
    task automatic test_quantize();
        int shifts [4] = '{0, 5, 8, 15};
        int chans  [4] = '{1, 2, 4, 0};
        int i;
        for (i = 0; i < 4; i++)
        begin
            wait_idle();
            apply_config(0, 0, 0, 0, 1, shifts[i], chans[i]);
            send_pixel(pix(7, 7, 24'hB75CE3), 1'b1);
        end
    endtask

    // equal counts: the lower bin wins even though it came second
    task automatic test_tie_order();
        wait_idle();
        apply_config(0, 0, 0, 0, 3, 4, 3);
        send_pixel(pix(1, 1, 24'hF00000), 1'b0);
        send_pixel(pix(2, 2, 24'h100000), 1'b1);
    endtask

    task automatic test_random_frames();
        int          l, t, r, b, band, shift, chans, frames, len, k, sel;
        int          rand_pixels, rand_frames;
        logic [23:0] palette [3];
        pixel_t      p;
        rand_pixels = 0;
        rand_frames = 0;
        while (rand_pixels < RANDOM_PIXELS || rand_frames < RANDOM_FRAMES)
        begin
            wait_idle();
            sel = $urandom_range(0, 9);
            band = (sel == 0) ? 1 : (sel == 1) ? 256 : (sel == 2) ? 0
                 : $urandom_range(1, 12);
            case ($urandom_range(0, 5))
                0:
                begin
                    l = 0; t = 0; r = 0; b = 0;
                end
                1:
                begin
                    l = 0; t = 0; r = 65535; b = 65535;
                end
                2:
                begin
                    // inverted region: every pixel lands in the band
                    r = $urandom_range(0, 65000);
                    l = r + $urandom_range(1, 500);
                    b = $urandom_range(0, 65000);
                    t = b + $urandom_range(1, 500);
                end
                default:
                begin
                    l = $urandom_range(0, 65535);
                    t = $urandom_range(0, 65535);
                    r = l + $urandom_range(1, 80);
                    b = t + $urandom_range(1, 80);
                    if (r > 65535)
                        r = 65535;
                    if (b > 65535)
                        b = 65535;
                end
            endcase
            shift = ($urandom_range(0, 9) < 7) ? $urandom_range(4, 8) : $urandom_range(0, 15);
            chans = $urandom_range(0, 4);
            apply_config(l, t, r, b, band, shift, chans);
            frames = $urandom_range(1, 4);
            repeat (frames)
            begin
                no_idle = ($urandom_range(0, 4) == 0);
                for (k = 0; k < 3; k++)
                    palette[k] = 24'($urandom);
                len = $urandom_range(1, 24);
                for (k = 0; k < len; k++)
                begin
                    p.x = rand_coord(win_left, win_right);
                    p.y = rand_coord(win_top, win_bottom);
                    sel = $urandom_range(0, 9);
                    if (sel < 7)
                        {p.red, p.green, p.blue} = palette[sel % 3] ^
                                                   (24'($urandom) & 24'h070707);
                    else
                        {p.red, p.green, p.blue} = 24'($urandom);
                    send_pixel(p, k == len - 1);
                end
                rand_pixels += len;
                rand_frames++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_REGION_LEFT;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_default_registers();
        test_border_band();
        test_quantize();
        test_tie_order();
        test_random_frames();
        wait_idle();

        $display("Sent %0d pixels in %0d frames over %0d register settings, %0d results.",
                 pixels_sent, frames_sent, cfg_settings, results_seen);
        $display("Band edges, clamped exponents, channel counts, empty frames, ties: %0d errors",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
